[sv/srs_pkg.sv]
`timescale 1ns / 1ps

package srs_pkg;

	localparam int VALUE_W   = 32;
	localparam int IDX_W     = 11;
	localparam int DEPTH_DEF = 1024;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

endpackage

[sv/srs_req_if.sv]
`timescale 1ns / 1ps

interface srs_req_if;
	import srs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      func;
	logic signed [VALUE_W-1:0] value;
	logic                      start_set;

	modport source (output valid, func, value, start_set, input ready);
	modport sink (input valid, func, value, start_set, output ready);
endinterface

[sv/srs_rsp_if.sv]
`timescale 1ns / 1ps

interface srs_rsp_if;
	import srs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    found;
	logic signed [IDX_W-1:0] first_index;
	logic signed [IDX_W-1:0] last_index;

	modport source (output valid, found, first_index, last_index, input ready);
	modport sink (input valid, found, first_index, last_index, output ready);
endinterface

[sv/srs_store.sv]
`timescale 1ns / 1ps

module srs_store #(
	parameter int DEPTH = srs_pkg::DEPTH_DEF,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [IW-1:0]               wr_addr,
	input  logic [srs_pkg::VALUE_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [IW-1:0]               rd_addr,
	output logic [srs_pkg::VALUE_W-1:0] rd_data
);
	import srs_pkg::*;

	logic [VALUE_W-1:0] mem_q [DEPTH];
	logic [VALUE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

[sv/sorted_range_search_unit.sv]
`timescale 1ns / 1ps
// load request: accepted while idle and does not leave idle, so the next request is accepted the cycle after
// query request: a lower-bound binary search, then an upper-bound one only when the key is found;
// each probe is a memory read plus a compare
// not ready while a query runs; the result register frees the input side
// reset clears the element count, sequencer and result valid; stored values are not cleared
module sorted_range_search_unit #(
	parameter int DEPTH = srs_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	srs_req_if.sink   req,
	srs_rsp_if.source rsp
);
	import srs_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = CW + IDX_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic               phase_q;
	logic [CW-1:0]      count_q;
	logic [VALUE_W-1:0] key_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      hp_q;
	logic [CW-1:0]      res_q;
	logic               eq_q;
	logic [CW-1:0]      lb_q;
	logic               fnd_q;

	logic             rsp_valid_q;
	logic             rsp_found_q;
	logic [IDX_W-1:0] rsp_first_q;
	logic [IDX_W-1:0] rsp_last_q;

	logic               req_fire;
	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	logic               rd_en;
	logic [VALUE_W-1:0] rd_data;
	logic [CW:0]        mid_sum;
	logic [CW-1:0]      mid;
	logic               live;
	logic               gt;
	logic               eq;
	logic               hit;
	logic [EW-1:0]      lb_ext;
	logic [EW-1:0]      ub_m1;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;

	// load: start_set restarts at entry zero, full array drops the element
	assign wr_en   = req_fire && (req.func == FUNC_LOAD)
		&& (req.start_set || (count_q < CW'(DEPTH)));
	assign wr_addr = req.start_set ? '0 : count_q[IW-1:0];

	// closed interval [lo, hp-1], mid = (lo + hp - 1) / 2
	assign live    = lo_q < hp_q;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hp_q} - (CW+1)'(1);
	assign mid     = mid_sum[CW:1];
	assign rd_en   = (state_q == ST_PROBE) && live;

	srs_store #(.DEPTH(DEPTH), .IW(IW)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (req.value),
		.rd_en   (rd_en),
		.rd_addr (mid[IW-1:0]),
		.rd_data (rd_data)
	);

	// shared compare unit, used by both searches
	assign gt  = $signed(rd_data) > $signed(key_q);
	assign eq  = rd_data == key_q;
	assign hit = phase_q ? gt : (gt || eq);

	assign lb_ext = {{IDX_W{1'b0}}, lb_q};
	assign ub_m1  = {{IDX_W{1'b0}}, res_q} - EW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			phase_q     <= 1'b0;
			fnd_q       <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.func == FUNC_QUERY) begin
							key_q   <= req.value;
							lo_q    <= '0;
							hp_q    <= count_q;
							res_q   <= count_q;
							eq_q    <= 1'b0;
							phase_q <= 1'b0;
							state_q <= ST_PROBE;
						end else if (req.start_set) begin
							count_q <= CW'(1);
						end else if (count_q < CW'(DEPTH)) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				ST_PROBE: begin
					if (live) begin
						state_q <= ST_CMP;
					end else if (!phase_q) begin
						if ((res_q == count_q) || !eq_q) begin
							fnd_q   <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							// lower bound holds the key, run the upper bound
							lb_q    <= res_q;
							phase_q <= 1'b1;
							lo_q    <= '0;
							hp_q    <= count_q;
							res_q   <= count_q;
						end
					end else begin
						fnd_q   <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_CMP: begin
					if (hit) begin
						res_q <= mid;
						hp_q  <= mid;
						eq_q  <= eq;
					end else begin
						lo_q <= mid + CW'(1);
					end
					state_q <= ST_PROBE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_found_q <= fnd_q;
						rsp_first_q <= fnd_q ? lb_ext[IDX_W-1:0] : '1;
						rsp_last_q  <= fnd_q ? ub_m1[IDX_W-1:0] : '1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.first_index = rsp_first_q;
	assign rsp.last_index  = rsp_last_q;
endmodule

[sv/srs_checker.sv]
`timescale 1ns / 1ps

module srs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      req_func,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic                      rsp_found,
	input logic [srs_pkg::IDX_W-1:0] rsp_first_index,
	input logic [srs_pkg::IDX_W-1:0] rsp_last_index
);
	import srs_pkg::*;

	// a miss always reports both indices as -1
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> (&rsp_first_index) && (&rsp_last_index))
		else $error("miss without -1 indices");

	// a query request blocks the input while the search runs
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_func == FUNC_QUERY) |=> !req_ready)
		else $error("ready during query search");

	// a load request leaves the input ready for the next request
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_func == FUNC_LOAD) |=> req_ready)
		else $error("load request stalled the input");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
			&& $stable(rsp_first_index) && $stable(rsp_last_index))
		else $error("result changed while stalled");
endmodule

bind sorted_range_search_unit srs_checker u_srs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_func        (req.func),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_found       (rsp.found),
	.rsp_first_index (rsp.first_index),
	.rsp_last_index  (rsp.last_index)
);

[bench/tb.sv]
`timescale 1ns / 1ps

typedef struct packed {
	logic                           found;
	logic signed [srs_pkg::IDX_W-1:0] first_idx;
	logic signed [srs_pkg::IDX_W-1:0] last_idx;
} search_result_t;

class range_search_board;
	logic signed [srs_pkg::VALUE_W-1:0] elems [srs_pkg::DEPTH_DEF];
	int                                 n_elems;
	search_result_t                     pending [$];
	int                                 errors;

	function new();
		n_elems = 0;
		errors  = 0;
	endfunction

	// closed-interval search: first index with elem >= key, or > key when strict
	function int bound(logic signed [srs_pkg::VALUE_W-1:0] key, bit strict);
		int lo, hi, mid, res;
		lo  = 0;
		hi  = n_elems - 1;
		res = n_elems;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (strict ? (elems[mid] > key) : (elems[mid] >= key)) begin
				res = mid;
				hi  = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		return res;
	endfunction

	function void note_request(srs_pkg::func_t f, logic signed [srs_pkg::VALUE_W-1:0] v,
		logic s);
		search_result_t r;
		int             lb, ub;
		if (f == srs_pkg::FUNC_LOAD) begin
			if (s)
				n_elems = 0;
			if (n_elems < srs_pkg::DEPTH_DEF) begin
				elems[n_elems] = v;
				n_elems++;
			end
			return;
		end
		lb = bound(v, 1'b0);
		if (lb >= n_elems || elems[lb] != v) begin
			r.found     = 1'b0;
			r.first_idx = '1;
			r.last_idx  = '1;
		end else begin
			ub          = bound(v, 1'b1);
			r.found     = 1'b1;
			r.first_idx = lb[srs_pkg::IDX_W-1:0];
			r.last_idx  = srs_pkg::IDX_W'(ub - 1);
		end
		pending.push_back(r);
	endfunction

	task report(string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		errors++;
	endtask

	task check_result(logic found, logic signed [srs_pkg::IDX_W-1:0] first_idx,
		logic signed [srs_pkg::IDX_W-1:0] last_idx);
		search_result_t e;
		if (pending.size() == 0) begin
			report("result with no query outstanding");
			return;
		end
		e = pending.pop_front();
		if (found !== e.found)
			report($sformatf("found %b, expected %b", found, e.found));
		if (first_idx !== e.first_idx)
			report($sformatf("first_index %0d, expected %0d", first_idx, e.first_idx));
		if (last_idx !== e.last_idx)
			report($sformatf("last_index %0d, expected %0d", last_idx, e.last_idx));
	endtask
endclass

module tb;
	import srs_pkg::*;

	localparam int          INT_MIN     = 32'sh8000_0000;
	localparam int          INT_MAX     = 32'sh7fff_ffff;
	localparam int          IDLE_PCT    = 27;
	localparam int          N_ITEMS     = 1800;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	bit   calm;
	int   sent;
	int unsigned cycle_count;

	range_search_board board;

	srs_req_if req ();
	srs_rsp_if rsp ();

	sorted_range_search_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid === 1'b1 && req.ready === 1'b1)
				board.note_request(func_t'(req.func), req.value, req.start_set);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
				board.check_result(rsp.found, rsp.first_index, rsp.last_index);
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(func_t f, int v, logic s);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid     <= 1'b1;
		req.func      <= f;
		req.value     <= v;
		req.start_set <= s;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(negedge clk);
		while (board.pending.size() != 0)
			@(negedge clk);
	endtask

	function automatic int pick_key(int cur[$]);
		int r;
		int k;
		r = $urandom_range(99);
		if (cur.size() != 0 && r < 55)
			return cur[$urandom_range(cur.size() - 1)];
		if (cur.size() != 0 && r < 80) begin
			k = cur[$urandom_range(cur.size() - 1)];
			return $urandom_range(1) ? k + 1 : k - 1;
		end
		if (r < 90) begin
			case ($urandom_range(2))
				0: return INT_MIN;
				1: return INT_MAX;
				default: return 0;
			endcase
		end
		return $urandom;
	endfunction

	initial begin
		int  cur [$];
		int  n, base, v, k;
		int  calm_until;
		bit  did_full;
		bit  narrow;
		int  kind;

		board         = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		calm          = 1'b0;
		sent          = 0;
		cycle_count   = 0;
		did_full      = 1'b0;
		calm_until    = 0;
		req.valid     = 1'b0;
		req.func      = FUNC_LOAD;
		req.value     = '0;
		req.start_set = 1'b0;
		rsp.ready     = 1'b0;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// queries on the empty array after reset
		send_item(FUNC_QUERY, 0, 1'b1);
		send_item(FUNC_QUERY, INT_MIN, 1'b0);

		// extremes with duplicate runs at both ends and in the middle
		cur = '{INT_MIN, INT_MIN, -1, 0, 0, 0, 7, INT_MAX, INT_MAX};
		foreach (cur[i])
			send_item(FUNC_LOAD, cur[i], i == 0);
		send_item(FUNC_QUERY, INT_MIN, 1'b0);
		send_item(FUNC_QUERY, 0, 1'b1);
		send_item(FUNC_QUERY, INT_MAX, 1'b0);
		send_item(FUNC_QUERY, -1, 1'b0);
		send_item(FUNC_QUERY, 7, 1'b1);
		send_item(FUNC_QUERY, 1, 1'b0);
		send_item(FUNC_QUERY, INT_MAX - 1, 1'b0);
		send_item(FUNC_QUERY, INT_MIN + 1, 1'b0);

		// single element set
		cur = '{42};
		send_item(FUNC_LOAD, 42, 1'b1);
		send_item(FUNC_QUERY, 42, 1'b0);
		send_item(FUNC_QUERY, 41, 1'b0);
		send_item(FUNC_QUERY, 43, 1'b1);

		drain();

		while (sent < N_ITEMS) begin
			if (!did_full && sent >= 400) begin
				// fill to capacity, then loads that must be dropped
				did_full = 1'b1;
				cur.delete();
				v = INT_MIN + $urandom_range(2);
				for (int i = 0; i < DEPTH_DEF - 1; i++) begin
					cur.push_back(v);
					if ($urandom_range(3) != 0)
						v += $urandom_range(1, 3);
				end
				cur.push_back(INT_MAX);
				foreach (cur[i])
					send_item(FUNC_LOAD, cur[i], i == 0);
				repeat (6)
					send_item(FUNC_LOAD, $urandom, 1'b0);
				repeat (24)
					send_item(FUNC_QUERY, pick_key(cur), 1'($urandom_range(1)));
				drain();
				calm       = 1'b1;
				calm_until = sent + 200;
			end
			if (calm && sent >= calm_until)
				calm = 1'b0;

			kind = $urandom_range(99);
			if (kind >= 8) begin
				n      = ($urandom_range(9) == 0) ? $urandom_range(49, 120) : $urandom_range(1, 24);
				narrow = 1'($urandom_range(1));
				base   = $urandom;
				cur.delete();
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(19) == 0)
						v = $urandom_range(1) ? INT_MAX : INT_MIN;
					else if (narrow)
						v = base + $urandom_range(n);
					else
						v = $urandom;
					cur.push_back(v);
				end
				// a few sets stay unsorted
				if (kind >= 18)
					cur.sort();
				foreach (cur[i])
					send_item(FUNC_LOAD, cur[i], i == 0);
			end
			k = $urandom_range(1, 10);
			repeat (k)
				send_item(FUNC_QUERY, pick_key(cur), 1'($urandom_range(1)));
		end

		drain();
		repeat (64) @(negedge clk);
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

[filelist.f]
sv/srs_pkg.sv
sv/srs_req_if.sv
sv/srs_rsp_if.sv
sv/srs_store.sv
sv/sorted_range_search_unit.sv
sv/srs_checker.sv
bench/tb.sv
